### sv/assert_macros.svh
// ============================================================================
// assert_macros.svh
// Assertion macros used by the checker module of the project.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an active-low reset that disables it.
`define ACH_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("anagram check assertion failed");

// Same-cycle implication built on the macro above.
`define ACH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    `ACH_ASSERT(lbl, clk, rstn, (ante) |-> (cons))

// Next-cycle implication built on the first macro.
`define ACH_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    `ACH_ASSERT(lbl, clk, rstn, (ante) |=> (cons))

`endif

### sv/ach_pkg.sv
// ============================================================================
// ach_pkg
// Shared constants and types of the anagram histogram check.
// ============================================================================
package ach_pkg;

    localparam int unsigned     ALPHABET_DEF = 256;
    localparam longint unsigned MAX_LEN_DEF  = 65535;
    localparam int              BYTE_W       = 8;
    localparam int              BAL_W        = 17;
    localparam int              TALLY_W      = 9;

    typedef struct packed {
        logic load;
        logic commit;
        logic clear;
    } t_lane_ctrl;

    typedef struct packed {
        logic [BAL_W-1:0] cnt_own;
        logic [BAL_W-1:0] cnt_other;
    } t_lane_view;

    typedef struct packed {
        logic valid;
        logic last;
        logic en_s;
        logic en_t;
        logic same;
        logic empty;
        logic ovf;
    } t_stage;

endpackage

### sv/anagram_histogram_check_core.sv
// ============================================================================
// anagram_histogram_check_core
// Decides whether two equal-length byte strings are anagrams of each other.
// ============================================================================
// Each input item carries the bytes of both strings at one position; an item
// with i_last high closes the pair, and an item with i_has_chars low carries
// no bytes (a lone such item with i_last closes an empty pair, whose verdict
// is the configuration bit written through i_cfg_wr_en and i_cfg_wr_data).
// One item is accepted per cycle while i_valid is high and o_stall is low.
// Two lanes, one per string, each own a byte-count memory with two read
// ports and one write port; the merging stage turns both lanes' counts into
// the tally of nonzero byte balances. The memory read and the merge are each
// registered: the last item of a pair enters the stage register, and o_valid
// rises when that stage commits. A new pair needs no idle gap after the
// previous one. Sustained rate is one item per clock while o_stall is low.
// Reset is synchronous: it empties the pipeline, clears every count by its
// valid bit at once, and sets the empty-pair verdict to no match.
// A result held by i_stall stays in the output register; items keep flowing
// until another closing item reaches the merging stage, which then holds
// and raises o_stall.
// ============================================================================
module anagram_histogram_check_core #(
    parameter int unsigned     ALPHABET = ach_pkg::ALPHABET_DEF,
    parameter longint unsigned MAX_LEN  = ach_pkg::MAX_LEN_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic                       i_cfg_wr_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [ach_pkg::BYTE_W-1:0] i_byte_s,
    input  logic [ach_pkg::BYTE_W-1:0] i_byte_t,
    input  logic                       i_has_chars,
    input  logic                       i_last,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_is_anagram,
    output logic                       o_too_long
);
    import ach_pkg::*;

    localparam int LEN_W = $clog2(MAX_LEN + 1);

    logic             r_empty_is_match;
    logic [LEN_W-1:0] r_len;
    logic             r_ovf;
    t_stage           r_stage;
    t_stage           n_stage;

    logic       out_valid;
    logic       adv;
    logic       accept;
    logic       commit;
    logic       counted;
    t_lane_ctrl lane_ctrl;
    t_lane_view view_s;
    t_lane_view view_t;

    assign adv     = !r_stage.valid || !r_stage.last || !out_valid || !i_stall;
    assign o_stall = !adv;
    assign accept  = i_valid && adv;
    assign commit  = r_stage.valid && adv;
    assign counted = i_has_chars && (r_len < LEN_W'(MAX_LEN));

    always_comb begin
        n_stage.valid = 1'b1;
        n_stage.last  = i_last;
        n_stage.en_s  = counted && ({1'b0, i_byte_s} < (BYTE_W + 1)'(ALPHABET));
        n_stage.en_t  = counted && ({1'b0, i_byte_t} < (BYTE_W + 1)'(ALPHABET));
        n_stage.same  = (i_byte_s == i_byte_t);
        n_stage.ovf   = r_ovf || (i_has_chars && !counted);
        n_stage.empty = (r_len == '0) && !counted && !n_stage.ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_is_match <= 1'b0;
            r_len            <= '0;
            r_ovf            <= 1'b0;
            r_stage          <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_empty_is_match <= i_cfg_wr_data;
            end
            if (accept) begin
                r_stage <= n_stage;
                if (i_last) begin
                    r_len <= '0;
                    r_ovf <= 1'b0;
                end else begin
                    r_len <= r_len + LEN_W'(counted);
                    r_ovf <= n_stage.ovf;
                end
            end else if (adv) begin
                r_stage.valid <= 1'b0;
            end
        end
    end

    assign lane_ctrl.load   = accept;
    assign lane_ctrl.commit = commit;
    assign lane_ctrl.clear  = r_stage.last;

    ach_lane #(
        .ALPHABET (ALPHABET)
    ) u_lane_s (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (lane_ctrl),
        .i_addr_own   (i_byte_s),
        .i_addr_other (i_byte_t),
        .i_cnt_en     (n_stage.en_s),
        .o_view       (view_s)
    );

    ach_lane #(
        .ALPHABET (ALPHABET)
    ) u_lane_t (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (lane_ctrl),
        .i_addr_own   (i_byte_t),
        .i_addr_other (i_byte_s),
        .i_cnt_en     (n_stage.en_t),
        .o_view       (view_t)
    );

    ach_merge u_merge (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_stage          (r_stage),
        .i_commit         (commit),
        .i_view_s         (view_s),
        .i_view_t         (view_t),
        .i_empty_is_match (r_empty_is_match),
        .i_stall          (i_stall),
        .o_valid          (out_valid),
        .o_is_anagram     (o_is_anagram),
        .o_too_long       (o_too_long)
    );

    assign o_valid = out_valid;

endmodule

### sv/ach_lane.sv
// ============================================================================
// ach_lane
// One counting lane: a per-byte occurrence memory read at two addresses,
// with write forwarding and per-entry valid bits that clear a pair at once.
// ============================================================================
module ach_lane #(
    parameter int unsigned ALPHABET = ach_pkg::ALPHABET_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ach_pkg::t_lane_ctrl        i_ctrl,
    input  logic [ach_pkg::BYTE_W-1:0] i_addr_own,
    input  logic [ach_pkg::BYTE_W-1:0] i_addr_other,
    input  logic                       i_cnt_en,
    output ach_pkg::t_lane_view        o_view
);
    import ach_pkg::*;

    localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

    logic [BAL_W-1:0]    mem [ALPHABET];
    logic [ALPHABET-1:0] r_vld;
    logic [ALPHABET-1:0] n_vld;

    logic [AW-1:0]    r_addr_own;
    logic             r_en;
    logic             r_fresh;
    logic [BAL_W-1:0] r_rd_own;
    logic [BAL_W-1:0] r_rd_other;
    logic             r_vld_own;
    logic             r_vld_other;
    logic             r_fwd_own;
    logic             r_fwd_other;
    logic [BAL_W-1:0] r_fwd_data;

    logic [AW-1:0]    ld_own;
    logic [AW-1:0]    ld_other;
    logic             wr_en;
    logic [BAL_W-1:0] cnt_own;
    logic [BAL_W-1:0] cnt_other;
    logic [BAL_W-1:0] wr_data;

    assign ld_own   = i_addr_own[AW-1:0];
    assign ld_other = i_addr_other[AW-1:0];
    assign wr_en    = i_ctrl.commit && r_en;

    always_comb begin
        if (r_fresh) begin
            cnt_own = '0;
        end else if (r_fwd_own) begin
            cnt_own = r_fwd_data;
        end else if (r_vld_own) begin
            cnt_own = r_rd_own;
        end else begin
            cnt_own = '0;
        end
        if (r_fresh) begin
            cnt_other = '0;
        end else if (r_fwd_other) begin
            cnt_other = r_fwd_data;
        end else if (r_vld_other) begin
            cnt_other = r_rd_other;
        end else begin
            cnt_other = '0;
        end
    end

    assign wr_data          = cnt_own + BAL_W'(1);
    assign o_view.cnt_own   = cnt_own;
    assign o_view.cnt_other = cnt_other;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_addr_own] <= wr_data;
        end
        if (i_ctrl.load) begin
            r_rd_own    <= mem[ld_own];
            r_rd_other  <= mem[ld_other];
            r_vld_own   <= r_vld[ld_own];
            r_vld_other <= r_vld[ld_other];
            r_fwd_own   <= wr_en && (r_addr_own == ld_own);
            r_fwd_other <= wr_en && (r_addr_own == ld_other);
            r_fwd_data  <= wr_data;
            r_addr_own  <= ld_own;
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (i_ctrl.commit && i_ctrl.clear) begin
            n_vld = '0;
        end else if (wr_en) begin
            n_vld[r_addr_own] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_en    <= 1'b0;
            r_fresh <= 1'b0;
        end else begin
            r_vld <= n_vld;
            if (i_ctrl.load) begin
                r_en    <= i_cnt_en;
                r_fresh <= i_ctrl.commit && i_ctrl.clear;
            end
        end
    end

endmodule

### sv/ach_merge.sv
// ============================================================================
// ach_merge
// Merging stage: combines both lanes into the nonzero tally and registers
// the verdict of a finished pair.
// ============================================================================
module ach_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ach_pkg::t_stage     i_stage,
    input  logic                i_commit,
    input  ach_pkg::t_lane_view i_view_s,
    input  ach_pkg::t_lane_view i_view_t,
    input  logic                i_empty_is_match,
    input  logic                i_stall,
    output logic                o_valid,
    output logic                o_is_anagram,
    output logic                o_too_long
);
    import ach_pkg::*;

    function automatic logic [TALLY_W-1:0] tally_delta(
        input logic [BAL_W-1:0] old_v,
        input logic [BAL_W-1:0] new_v
    );
        logic [TALLY_W-1:0] d;
        if (old_v == '0) begin
            d = TALLY_W'(1);
        end else if (new_v == '0) begin
            d = '1;
        end else begin
            d = '0;
        end
        return d;
    endfunction

    logic [TALLY_W-1:0] r_tally;
    logic               r_out_valid;
    logic               r_is_anagram;
    logic               r_too_long;

    logic [BAL_W-1:0]   bal_bs;
    logic [BAL_W-1:0]   bal_bt;
    logic [BAL_W-1:0]   new1;
    logic [BAL_W-1:0]   old2;
    logic [BAL_W-1:0]   new2;
    logic [TALLY_W-1:0] d1;
    logic [TALLY_W-1:0] d2;
    logic [TALLY_W-1:0] tally_sum;
    logic               verdict;
    logic               flag_long;

    // The byte of the first string is applied before the byte of the second.
    assign bal_bs    = i_view_s.cnt_own - i_view_t.cnt_other;
    assign bal_bt    = i_view_s.cnt_other - i_view_t.cnt_own;
    assign new1      = bal_bs + BAL_W'(1);
    assign d1        = i_stage.en_s ? tally_delta(bal_bs, new1) : '0;
    assign old2      = (i_stage.same && i_stage.en_s) ? new1 : bal_bt;
    assign new2      = old2 - BAL_W'(1);
    assign d2        = i_stage.en_t ? tally_delta(old2, new2) : '0;
    assign tally_sum = r_tally + d1 + d2;

    always_comb begin
        if (i_stage.empty) begin
            verdict   = i_empty_is_match;
            flag_long = 1'b0;
        end else if (i_stage.ovf) begin
            verdict   = 1'b0;
            flag_long = 1'b1;
        end else begin
            verdict   = (tally_sum == '0);
            flag_long = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_commit) begin
                r_tally <= i_stage.last ? '0 : tally_sum;
            end
            if (i_commit && i_stage.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_commit && i_stage.last) begin
            r_is_anagram <= verdict;
            r_too_long   <= flag_long;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_is_anagram = r_is_anagram;
    assign o_too_long   = r_too_long;

endmodule

### sv/ach_checker.sv
// ============================================================================
// ach_checker
// Port-level checks of the anagram histogram check, bound to the top level.
// ============================================================================
`include "assert_macros.svh"

module ach_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_wr_en,
    input logic       i_cfg_wr_data,
    input logic       i_valid,
    input logic       o_stall,
    input logic [7:0] i_byte_s,
    input logic [7:0] i_byte_t,
    input logic       i_has_chars,
    input logic       i_last,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_is_anagram,
    input logic       o_too_long
);

    // A stalled result stays in place.
    `ACH_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_is_anagram) && $stable(o_too_long))

    // An overlong pair never reports a match.
    `ACH_ASSERT_IMP(a_long_no_match, i_clk, i_rst_n, o_valid && o_too_long, !o_is_anagram)

    // Intake stalls only behind a result the receiver is holding.
    `ACH_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)

endmodule

bind anagram_histogram_check_core ach_checker u_ach_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_wr_en   (i_cfg_wr_en),
    .i_cfg_wr_data (i_cfg_wr_data),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_byte_s      (i_byte_s),
    .i_byte_t      (i_byte_t),
    .i_has_chars   (i_has_chars),
    .i_last        (i_last),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_is_anagram  (o_is_anagram),
    .o_too_long    (o_too_long)
);
